### hdl/ecft_pkg.sv
`default_nettype none

package ecft_pkg;

    localparam int PRIME_BITS  = 10;
    localparam int CNT_W       = $clog2(PRIME_BITS);
    localparam int EXP_W       = PRIME_BITS - 1;
    localparam int SUM_W       = PRIME_BITS + 2;
    localparam int COEF_W      = 10;
    localparam int TRACE_W     = 8;
    localparam int ORDER_W     = 11;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int TRACE_MAX   = 127;
    localparam int TRACE_MIN   = -128;

    localparam logic [PRIME_BITS-1:0] PRIME_RESET = PRIME_BITS'(401);
    localparam logic [PRIME_BITS-1:0] MIN_PRIME   = PRIME_BITS'(5);
    localparam logic [PRIME_BITS-1:0] MUL_FOUR    = PRIME_BITS'(4);
    localparam logic [PRIME_BITS-1:0] MUL_27      = PRIME_BITS'(27);

    // word index of the modulus register (paddr[2])
    localparam logic REG_PRIME = 1'b0;

    typedef struct packed {
        logic                  start;
        logic [PRIME_BITS-1:0] x;
        logic [PRIME_BITS-1:0] y;
    } t_mm_req;

    typedef struct packed {
        logic                  done;
        logic [PRIME_BITS-1:0] prod;
    } t_mm_rsp;

    typedef struct packed {
        logic                      good;
        logic signed [TRACE_W-1:0] trace;
        logic [ORDER_W-1:0]        order;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_A2,
        S_A3,
        S_A3X4,
        S_B2,
        S_B2X27,
        S_DISC,
        S_XSQ,
        S_XCU,
        S_AX,
        S_RHS,
        S_POW_MUL,
        S_POW_SQR,
        S_TALLY,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### hdl/ecft_modmul.sv
`default_nettype none

// Bit-serial interleaved modular multiplier: x is scanned MSB first, one bit
// per cycle; y must be below p, x may be any value.
module ecft_modmul import ecft_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [PRIME_BITS-1:0] i_p,
    input  wire t_mm_req               i_req,
    output t_mm_rsp                    o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [PRIME_BITS-1:0] r_x;
    logic [PRIME_BITS-1:0] r_y;
    logic [PRIME_BITS-1:0] r_acc;
    logic [PRIME_BITS-1:0] n_acc;

    logic [PRIME_BITS:0]   dbl;
    logic [PRIME_BITS:0]   dbl_red;
    logic [PRIME_BITS:0]   sum;
    logic [PRIME_BITS:0]   sum_red;
    logic [PRIME_BITS:0]   p_ext;

    always_comb begin
        p_ext   = {1'b0, i_p};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = dbl_red + (r_x[PRIME_BITS-1] ? {1'b0, r_y} : '0);
        sum_red = (sum >= p_ext) ? sum - p_ext : sum;
        n_acc   = sum_red[PRIME_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PRIME_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= {r_x[PRIME_BITS-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

`default_nettype wire

### hdl/ecft_seq.sv
`default_nettype none

// Sequencer: reduces the coefficients, tests the discriminant, then walks x
// over the field and tallies the Euler character of each nonzero rhs.
module ecft_seq import ecft_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [PRIME_BITS-1:0] i_p,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [COEF_W-1:0]     i_a,
    input  wire logic [COEF_W-1:0]     i_b,
    output t_mm_req                    o_mm_req,
    input  wire t_mm_rsp               i_mm_rsp,
    output logic                       o_res_valid,
    output t_result                    o_res,
    input  wire logic                  i_res_take
);

    function automatic logic [PRIME_BITS-1:0] madd(
        input logic [PRIME_BITS-1:0] u,
        input logic [PRIME_BITS-1:0] v,
        input logic [PRIME_BITS-1:0] m
    );
        logic [PRIME_BITS:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[PRIME_BITS-1:0];
    endfunction

    t_state r_state;
    t_state n_state;
    logic   r_wait;

    logic [PRIME_BITS-1:0]   r_a;
    logic [PRIME_BITS-1:0]   r_b;
    logic [PRIME_BITS-1:0]   r_t;
    logic [PRIME_BITS-1:0]   r_u;
    logic [PRIME_BITS-1:0]   r_xv;
    logic [PRIME_BITS-1:0]   r_base;
    logic [PRIME_BITS-1:0]   r_acc;
    logic [EXP_W-1:0]        r_e;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_good;

    logic                    p_ok;
    logic [PRIME_BITS-1:0]   disc;
    logic [PRIME_BITS-1:0]   rhs;
    logic                    last_x;
    logic                    mul_on;
    logic [PRIME_BITS-1:0]   mul_x;
    logic [PRIME_BITS-1:0]   mul_y;
    logic                    done;
    logic signed [SUM_W-1:0] neg_sum;
    logic signed [TRACE_W-1:0] trace_sat;

    assign done   = i_mm_rsp.done;
    assign p_ok   = (i_p >= MIN_PRIME) && i_p[0];
    assign disc   = madd(r_t, r_u, i_p);
    assign rhs    = madd(madd(r_t, r_u, i_p), r_b, i_p);
    assign last_x = (r_xv == i_p - PRIME_BITS'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = p_ok ? S_RED_A : S_DONE;
            S_RED_A:   if (done) n_state = S_RED_B;
            S_RED_B:   if (done) n_state = S_A2;
            S_A2:      if (done) n_state = S_A3;
            S_A3:      if (done) n_state = S_A3X4;
            S_A3X4:    if (done) n_state = S_B2;
            S_B2:      if (done) n_state = S_B2X27;
            S_B2X27:   if (done) n_state = S_DISC;
            S_DISC:    n_state = (disc == '0) ? S_DONE : S_XSQ;
            S_XSQ:     if (done) n_state = S_XCU;
            S_XCU:     if (done) n_state = S_AX;
            S_AX:      if (done) n_state = S_RHS;
            S_RHS:     n_state = (rhs == '0) ? S_NEXT : S_POW_MUL;
            S_POW_MUL: begin
                if (!r_e[0] || done) begin
                    n_state = (r_e[EXP_W-1:1] == '0) ? S_TALLY : S_POW_SQR;
                end
            end
            S_POW_SQR: if (done) n_state = S_POW_MUL;
            S_TALLY:   n_state = S_NEXT;
            S_NEXT:    n_state = last_x ? S_DONE : S_XSQ;
            S_DONE:    if (i_res_take) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs: multiplier operands per step
    always_comb begin
        mul_on      = 1'b0;
        mul_x       = '0;
        mul_y       = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_RED_A:   begin mul_on = 1'b1; mul_x = r_a;      mul_y = PRIME_BITS'(1); end
            S_RED_B:   begin mul_on = 1'b1; mul_x = r_b;      mul_y = PRIME_BITS'(1); end
            S_A2:      begin mul_on = 1'b1; mul_x = r_a;      mul_y = r_a;    end
            S_A3:      begin mul_on = 1'b1; mul_x = r_t;      mul_y = r_a;    end
            S_A3X4:    begin mul_on = 1'b1; mul_x = MUL_FOUR; mul_y = r_t;    end
            S_B2:      begin mul_on = 1'b1; mul_x = r_b;      mul_y = r_b;    end
            S_B2X27:   begin mul_on = 1'b1; mul_x = MUL_27;   mul_y = r_u;    end
            S_XSQ:     begin mul_on = 1'b1; mul_x = r_xv;     mul_y = r_xv;   end
            S_XCU:     begin mul_on = 1'b1; mul_x = r_t;      mul_y = r_xv;   end
            S_AX:      begin mul_on = 1'b1; mul_x = r_a;      mul_y = r_xv;   end
            S_POW_MUL: begin mul_on = r_e[0]; mul_x = r_acc;  mul_y = r_base; end
            S_POW_SQR: begin mul_on = 1'b1; mul_x = r_base;   mul_y = r_base; end
            S_DONE:    o_res_valid = 1'b1;
            default:   ;
        endcase
    end

    assign o_mm_req.start = mul_on && !r_wait;
    assign o_mm_req.x     = mul_x;
    assign o_mm_req.y     = mul_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_mm_req.start) begin
                r_wait <= 1'b1;
            end else if (done) begin
                r_wait <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_a    <= PRIME_BITS'(i_a);
                    r_b    <= PRIME_BITS'(i_b);
                    r_good <= 1'b0;
                end
            end
            S_RED_A: if (done) r_a <= i_mm_rsp.prod;
            S_RED_B: if (done) r_b <= i_mm_rsp.prod;
            S_A2, S_A3, S_A3X4, S_XSQ, S_XCU: if (done) r_t <= i_mm_rsp.prod;
            S_B2, S_B2X27, S_AX: if (done) r_u <= i_mm_rsp.prod;
            S_DISC: begin
                r_xv   <= '0;
                r_sum  <= '0;
                r_good <= (disc != '0);
            end
            S_RHS: begin
                r_base <= rhs;
                r_acc  <= PRIME_BITS'(1);
                r_e    <= i_p[PRIME_BITS-1:1];
            end
            S_POW_MUL: if (done) r_acc <= i_mm_rsp.prod;
            S_POW_SQR: begin
                if (done) begin
                    r_base <= i_mm_rsp.prod;
                    r_e    <= r_e >> 1;
                end
            end
            S_TALLY: begin
                r_sum <= (r_acc == PRIME_BITS'(1)) ? r_sum + SUM_W'(1) : r_sum - SUM_W'(1);
            end
            S_NEXT: r_xv <= r_xv + PRIME_BITS'(1);
            default: ;
        endcase
    end

    // trace is the negated sum, clamped to the byte range
    always_comb begin
        neg_sum = -r_sum;
        priority if (neg_sum > $signed(SUM_W'(TRACE_MAX))) begin
            trace_sat = TRACE_W'(TRACE_MAX);
        end else if (neg_sum < $signed(SUM_W'(TRACE_MIN))) begin
            trace_sat = TRACE_W'(TRACE_MIN);
        end else begin
            trace_sat = neg_sum[TRACE_W-1:0];
        end
    end

    always_comb begin
        o_res = '0;
        if (r_good) begin
            o_res.good  = 1'b1;
            o_res.trace = trace_sat;
            o_res.order = ORDER_W'(i_p) + ORDER_W'(1)
                        - {{(ORDER_W-TRACE_W){trace_sat[TRACE_W-1]}}, trace_sat};
        end
    end

endmodule

`default_nettype wire

### hdl/elliptic_curve_frobenius_trace_top.sv
// Elliptic curve point counter. Each input word carries the coefficients a
// and b of y^2 = x^3 + a*x + b; the result word gives good reduction, the
// Frobenius trace and the group order over the prime p held in the modulus
// register (byte address 0, reset 401). One item runs on a single bit-serial
// modular multiplier. Seven products reduce the coefficients and form the
// discriminant, after which a singular curve gives its result; an unsupported
// modulus gives it without any product. Otherwise, for each of the p values
// of x, three products form the rhs and up to 2*PRIME_BITS - 3 form the Euler
// power, a zero exponent bit skipping its multiply. The input is not ready
// while an item is in work; a finished result waits in the output register
// while the next item runs.
// Write the modulus only while no item is in work or waiting.
`default_nettype none

module elliptic_curve_frobenius_trace_top import ecft_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // [9:0] curve_a, [19:10] curve_b
    input  wire logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [7:0] frobenius_trace, [18:8] point count
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,
    // [0] good_reduction
    output logic                        o_m_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [PRIME_BITS-1:0] r_prime;
    logic                  r_m_valid;
    t_result               r_res;

    t_mm_req  mm_req;
    t_mm_rsp  mm_rsp;
    logic     res_valid;
    t_result  res;
    logic     res_take;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(r_prime);
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PRIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= PRIME_RESET;
        end else if (cfg_wr) begin
            r_prime <= pwdata[PRIME_BITS-1:0];
        end
    end

    ecft_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_p         (r_prime),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_a         (i_s_axis_tdata[COEF_W-1:0]),
        .i_b         (i_s_axis_tdata[2*COEF_W-1:COEF_W]),
        .o_mm_req    (mm_req),
        .i_mm_rsp    (mm_rsp),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    ecft_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_p     (r_prime),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_m_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_res.good;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_res.order, r_res.trace});

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after accepting a word");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("singular curve with nonzero trace or order");

    a_take_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> o_m_axis_tvalid)
        else $error("result taken but output word not valid");

endmodule

`default_nettype wire

### tb/sv/elliptic_curve_frobenius_trace_top_test.sv
`timescale 1ns / 100ps

module elliptic_curve_frobenius_trace_top_test;
    import ecft_pkg::*;

    class curve_order_board;
        logic [PRIME_BITS-1:0] modulus;
        t_result               expected_orders[$];
        int                    mismatches;

        function new();
            modulus    = PRIME_RESET;
            mismatches = 0;
        endfunction

        function void set_modulus(logic [PRIME_BITS-1:0] value);
            modulus = value;
        endfunction

        function longint unsigned euler_power(longint unsigned base, longint unsigned ex,
                                              longint unsigned m);
            longint unsigned acc;
            acc  = 1 % m;
            base = base % m;
            while (ex != 0) begin
                if ((ex & 1) != 0) acc = (acc * base) % m;
                base = (base * base) % m;
                ex   = ex >> 1;
            end
            return acc;
        endfunction

        // Legendre character sum over x = 0 .. p-1
        function t_result count_curve(logic [COEF_W-1:0] a_in, logic [COEF_W-1:0] b_in);
            longint unsigned p, a, b, disc, half, rhs;
            int              sum, tr;
            t_result         res;
            res = '0;
            sum = 0;
            p   = modulus;
            if (p < 5 || p % 2 == 0) return res;
            a    = a_in % p;
            b    = b_in % p;
            disc = (4 * (((a * a) % p) * a % p) + 27 * ((b * b) % p)) % p;
            if (disc == 0) return res;
            half = (p - 1) / 2;
            for (longint unsigned x = 0; x < p; x++) begin
                rhs = ((((x * x) % p) * x % p) + (a * x) % p + b) % p;
                if (rhs != 0) begin
                    if (euler_power(rhs, half, p) == 1) sum++;
                    else sum--;
                end
            end
            tr = -sum;
            if (tr > TRACE_MAX) tr = TRACE_MAX;
            if (tr < TRACE_MIN) tr = TRACE_MIN;
            res.good  = 1'b1;
            res.trace = tr[TRACE_W-1:0];
            res.order = ORDER_W'(int'(p) + 1 - tr);
            return res;
        endfunction

        function void note_curve(logic [COEF_W-1:0] a_in, logic [COEF_W-1:0] b_in);
            expected_orders.insert(expected_orders.size(), count_curve(a_in, b_in));
        endfunction

        function void check_order(logic good, logic [TRACE_W-1:0] trace,
                                  logic [ORDER_W-1:0] order);
            t_result want;
            if (expected_orders.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: good=%0d trace=%0d order=%0d",
                             good, $signed(trace), order);
                return;
            end
            want = expected_orders.pop_front();
            if (want.good !== good || want.trace !== trace || want.order !== order) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected good=%0d trace=%0d order=%0d, ",
                              "got good=%0d trace=%0d order=%0d"},
                             want.good, want.trace, want.order, good, $signed(trace), order);
            end
        endfunction

        function int pending();
            return expected_orders.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    curve_order_board board;
    int idle_pct   = 21;
    int hold_start = 0;
    int hold_left  = 0;

    elliptic_curve_frobenius_trace_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random backpressure, plus a long hold when requested
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start > 0) begin
                hold_left  = hold_start;
                hold_start = 0;
            end
            if (hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready = ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_order(o_m_axis_tuser, o_m_axis_tdata[TRACE_W-1:0],
                              o_m_axis_tdata[TRACE_W +: ORDER_W]);
    end

    // valid stays high after acceptance; the next call redrives it at the falling edge
    task automatic send_curve(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  = {{(IN_DATA_W - 2*COEF_W){1'b0}}, b, a};
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_curve(a, b);
    endtask

    // drop valid and drain every outstanding word
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_modulus(input int unsigned value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'({REG_PRIME, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_modulus(value[PRIME_BITS-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_phase(input int unsigned p, input int count, input int hold);
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        settle();
        write_modulus(p);
        hold_start = hold;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) a = COEF_W'($urandom_range(p - 1));
            else a = COEF_W'($urandom_range((1 << COEF_W) - 1));
            if ($urandom_range(99) < 80) b = COEF_W'($urandom_range(p - 1));
            else b = COEF_W'($urandom_range((1 << COEF_W) - 1));
            send_curve(a, b);
        end
    endtask

    initial begin
        int unsigned phase_moduli[10];
        phase_moduli = '{5, 7, 11, 13, 6, 17, 19, 23, 31, 15};
        board           = new();
        i_rst_n         = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tvalid = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // modulus at its reset value
        send_curve(10'd0, 10'd0);
        send_curve(10'd1, 10'd1);

        settle();
        write_modulus(5);
        send_curve(10'd0, 10'd0);
        send_curve(10'h3FF, 10'h3FF);
        send_curve(10'd0, 10'd1);
        send_curve(10'd1, 10'd0);
        send_curve(10'd4, 10'd4);
        send_curve(10'd2, 10'd3);
        send_curve(10'd5, 10'd5);

        settle();
        write_modulus(1021);
        send_curve(10'd0, 10'd0);
        send_curve(10'd1020, 10'd1020);

        // odd composite modulus large enough for the trace to saturate
        settle();
        write_modulus(165);
        send_curve(10'd1, 10'd1);

        settle();
        write_modulus(9);
        send_curve(10'd1, 10'd2);
        send_curve(10'd0, 10'd1);

        // unsupported moduli: even or below five
        settle();
        write_modulus(4);
        send_curve(10'd1, 10'd1);
        send_curve(10'd0, 10'd0);
        settle();
        write_modulus(0);
        send_curve(10'd3, 10'd3);
        settle();
        write_modulus(1022);
        send_curve(10'd1, 10'd1);
        settle();
        write_modulus(3);
        send_curve(10'd1, 10'd1);

        for (int k = 0; k < 10; k++) begin
            idle_pct = (k == 3) ? 0 : 21;
            random_phase(phase_moduli[k], 10, (k == 0) ? 4000 : 0);
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (board.pending() == 0 && board.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### elliptic_curve_frobenius_trace_top.f
hdl/ecft_pkg.sv
hdl/ecft_modmul.sv
hdl/ecft_seq.sv
hdl/elliptic_curve_frobenius_trace_top.sv
tb/sv/elliptic_curve_frobenius_trace_top_test.sv
